// ===== hdl/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Shared types and constants for the configuration space enumerator.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int MaxDevices = 64;
    localparam int IdxW       = $clog2(MaxDevices);
    localparam int CntW       = IdxW + 1;
    localparam int WordsPerEntry = 10;
    localparam int TblDepth   = MaxDevices * 16;
    localparam int TblAw      = $clog2(TblDepth);

    // commands
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_REPLY = 2'd1;
    localparam logic [1:0] CMD_FIND  = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_REQ    = 3'd0;
    localparam logic [2:0] KIND_DONE   = 3'd1;
    localparam logic [2:0] KIND_FIND   = 3'd2;
    localparam logic [2:0] KIND_WORD   = 3'd3;
    localparam logic [2:0] KIND_REJECT = 3'd4;

    // scan phases
    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_PROBE_ID  = 3'd1;
    localparam logic [2:0] PH_PROBE_HDR = 3'd2;
    localparam logic [2:0] PH_FN_ID     = 3'd3;
    localparam logic [2:0] PH_FN_CLASS  = 3'd4;
    localparam logic [2:0] PH_FN_HDR    = 3'd5;
    localparam logic [2:0] PH_FN_BAR    = 3'd6;
    localparam logic [2:0] PH_FN_IRQ    = 3'd7;

    // table word codes
    localparam logic [3:0] W_IDS   = 4'd0;
    localparam logic [3:0] W_PLACE = 4'd1;
    localparam logic [3:0] W_CLASS = 4'd2;
    localparam logic [3:0] W_BAR0  = 4'd3;
    localparam logic [3:0] W_IRQ   = 4'd9;

    // controller to datapath
    typedef struct packed {
        logic       load;     // capture command inputs
        logic       reply;    // run one scan step
        logic       find_rd;  // read ids of the find pointer
        logic       find_chk; // compare read ids
        logic       word_rd;  // read the selected word
        logic       emit;     // drive a result
    } cse_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       find_hit;
        logic       find_last;
    } cse_stat_t;

endpackage

// ===== hdl/cse_ram.sv =====
// ----------------------------------------------------------------------------
// cse_ram
// Generic single port RAM with registered read.
// ----------------------------------------------------------------------------
module cse_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    // write or registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hdl/cse_datapath.sv =====
// ----------------------------------------------------------------------------
// cse_datapath
// Scan counters, entry table and result register of the enumerator.
// ----------------------------------------------------------------------------
module cse_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  cse_pkg::cse_cmd_t  ctl,
    output cse_pkg::cse_stat_t stat,
    input  logic [1:0]         cmd,
    input  logic [31:0]        reply_data,
    input  logic [15:0]        want_vendor,
    input  logic [15:0]        want_device,
    input  logic [5:0]         entry_select,
    input  logic [3:0]         word_select,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_data,
    output logic [2:0]         kind,
    output logic [7:0]         req_bus,
    output logic [4:0]         req_slot,
    output logic [2:0]         req_func,
    output logic [7:0]         req_offset,
    output logic               found,
    output logic [5:0]         entry_index,
    output logic [6:0]         device_count,
    output logic [31:0]        read_word
);
    import cse_pkg::*;

    logic [6:0]      max_reg;
    logic [7:0]      bus_reg, bus_next;
    logic [4:0]      slot_reg, slot_next;
    logic [2:0]      func_reg, func_next;
    logic [2:0]      phase_reg, phase_next;
    logic [2:0]      bar_reg, bar_next;
    logic            multi_reg, multi_next;
    logic [CntW-1:0] count_reg, count_next;
    logic [1:0]      cmd_reg;
    logic [31:0]     data_reg;
    logic [31:0]     key_reg;
    logic [IdxW-1:0] es_reg;
    logic [3:0]      ws_reg;
    logic [IdxW-1:0] fptr_reg;
    logic            out_valid_reg;
    logic [2:0]      kind_reg, kind_next;
    logic [7:0]      obus_reg, obus_next;
    logic [4:0]      oslot_reg, oslot_next;
    logic [2:0]      ofunc_reg, ofunc_next;
    logic [7:0]      ooff_reg, ooff_next;
    logic            ofound_reg, ofound_next;
    logic [5:0]      oidx_reg, oidx_next;
    logic [31:0]     oword_reg, oword_next;
    logic [31:0]     rword_reg;

    logic            we;
    logic [TblAw-1:0] addr;
    logic [31:0]     wdata, rdata;
    logic [CntW-1:0] lim;
    logic            ws_ok, es_ok;
    logic            done;

    // table word address: entry times 16 plus word
    function automatic logic [TblAw-1:0] taddr(input logic [IdxW-1:0] e, input logic [3:0] w);
        taddr = {e, w};
    endfunction

    cse_ram #(.Width(32), .Depth(TblDepth)) u_tbl (
        .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    assign lim = (max_reg < 7'(MaxDevices)) ? CntW'(max_reg) : CntW'(MaxDevices);
    assign es_ok = ({1'b0, es_reg} < count_reg);
    assign ws_ok = (ws_reg <= W_IRQ);
    assign stat.find_hit = ctl.find_chk && (rdata == key_reg);
    assign stat.find_last = ({1'b0, fptr_reg} + CntW'(1) >= count_reg);

    // scan step and table write
    always_comb
    begin
        bus_next = bus_reg; slot_next = slot_reg; func_next = func_reg;
        phase_next = phase_reg; bar_next = bar_reg; multi_next = multi_reg;
        count_next = count_reg;
        kind_next = KIND_REQ; obus_next = '0; oslot_next = '0; ofunc_next = '0;
        ooff_next = '0; ofound_next = 1'b0; oidx_next = '0; oword_next = '0;
        we = 1'b0; wdata = data_reg; addr = taddr(count_reg[IdxW-1:0], W_IDS);
        done = 1'b0;
        if (ctl.reply && cmd_reg == CMD_START)
        begin
            bus_next = '0; slot_next = '0; func_next = '0; bar_next = '0;
            multi_next = 1'b0; count_next = '0; phase_next = PH_PROBE_ID;
            ooff_next = 8'h00;
        end
        else if (ctl.reply)
        begin
            // default: next request
            ooff_next = 8'h00;
            unique case (phase_reg)
                PH_IDLE:
                begin
                    kind_next = KIND_REJECT;
                end
                PH_PROBE_ID:
                begin
                    if (data_reg[15:0] == 16'hFFFF)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        ooff_next = 8'h0C; phase_next = PH_PROBE_HDR;
                    end
                end
                PH_PROBE_HDR:
                begin
                    multi_next = data_reg[23]; func_next = '0; phase_next = PH_FN_ID;
                end
                PH_FN_ID:
                begin
                    if (data_reg[15:0] == 16'hFFFF || count_reg >= lim)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        we = 1'b1;
                        ooff_next = 8'h08; phase_next = PH_FN_CLASS;
                    end
                end
                PH_FN_CLASS:
                begin
                    // stash class bits in the data of the hdr step
                    we = 1'b1; addr = taddr(count_reg[IdxW-1:0], W_PLACE);
                    wdata = {16'h0, bus_reg, slot_reg, func_reg};
                    oword_next = {data_reg[31:8], 8'h00};
                    ooff_next = 8'h0C; phase_next = PH_FN_HDR;
                end
                PH_FN_HDR:
                begin
                    we = 1'b1; addr = taddr(count_reg[IdxW-1:0], W_CLASS);
                    wdata = {oword_reg[31:8], data_reg[23:16]};
                    bar_next = '0; ooff_next = 8'h10; phase_next = PH_FN_BAR;
                end
                PH_FN_BAR:
                begin
                    we = 1'b1;
                    addr = taddr(count_reg[IdxW-1:0], W_BAR0 + {1'b0, bar_reg});
                    if (bar_reg < 3'd5)
                    begin
                        bar_next = bar_reg + 3'd1;
                        ooff_next = 8'h10 + {3'b0, bar_next, 2'b00};
                    end
                    else
                    begin
                        ooff_next = 8'h3C; phase_next = PH_FN_IRQ;
                    end
                end
                PH_FN_IRQ:
                begin
                    we = 1'b1; addr = taddr(count_reg[IdxW-1:0], W_IRQ);
                    wdata = {24'h0, data_reg[7:0]};
                    count_next = count_reg + CntW'(1);
                    done = 1'b1;
                end
                default:
                begin
                    kind_next = KIND_REJECT;
                end
            endcase
            // advance function or slot
            if (done)
            begin
                ooff_next = 8'h00;
                if (phase_reg != PH_PROBE_ID && !(func_reg >= 3'd7 ||
                    (func_reg == 3'd0 && !multi_reg)))
                begin
                    func_next = func_reg + 3'd1; phase_next = PH_FN_ID;
                end
                else
                begin
                    func_next = '0; multi_next = 1'b0; phase_next = PH_PROBE_ID;
                    if (slot_reg != 5'd31)
                    begin
                        slot_next = slot_reg + 5'd1;
                    end
                    else
                    begin
                        slot_next = '0;
                        if (bus_reg != 8'd255)
                        begin
                            bus_next = bus_reg + 8'd1;
                        end
                        else
                        begin
                            bus_next = '0; phase_next = PH_IDLE; kind_next = KIND_DONE;
                        end
                    end
                end
            end
            if (kind_next == KIND_REQ)
            begin
                obus_next = bus_next; oslot_next = slot_next; ofunc_next = func_next;
            end
            else
            begin
                ooff_next = '0;
            end
        end
        else if (ctl.find_rd)
        begin
            addr = taddr(fptr_reg, W_IDS);
        end
        else if (ctl.word_rd)
        begin
            addr = taddr(es_reg, ws_reg);
        end
        else if (ctl.find_chk && stat.find_hit)
        begin
            addr = taddr(fptr_reg, W_PLACE);
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= 7'd64; bus_reg <= '0; slot_reg <= '0; func_reg <= '0;
            phase_reg <= PH_IDLE; bar_reg <= '0; multi_reg <= 1'b0; count_reg <= '0;
            out_valid_reg <= 1'b0; fptr_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
            out_valid_reg <= ctl.emit;
            if (ctl.reply)
            begin
                bus_reg <= bus_next; slot_reg <= slot_next; func_reg <= func_next;
                phase_reg <= phase_next; bar_reg <= bar_next; multi_reg <= multi_next;
                count_reg <= count_next;
            end
            if (ctl.load)
            begin
                fptr_reg <= '0;
            end
            else if (ctl.find_chk && !stat.find_hit)
            begin
                fptr_reg <= fptr_reg + IdxW'(1);
            end
        end
    end

    // command capture and result fields
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg <= cmd; data_reg <= reply_data;
            key_reg <= {want_device, want_vendor};
            es_reg <= entry_select; ws_reg <= word_select;
            ofound_reg <= 1'b0;
        end
        if (ctl.reply)
        begin
            kind_reg <= kind_next; obus_reg <= obus_next; oslot_reg <= oslot_next;
            ofunc_reg <= ofunc_next; ooff_reg <= ooff_next; ofound_reg <= ofound_next;
            oidx_reg <= oidx_next;
            if (phase_reg == PH_FN_CLASS && cmd_reg == CMD_REPLY)
            begin
                oword_reg <= oword_next;
            end
            else
            begin
                oword_reg <= '0;
            end
        end
        if (ctl.find_chk && stat.find_hit)
        begin
            ofound_reg <= 1'b1; oidx_reg <= fptr_reg;
        end
        // hold the table word read for the result cycle
        if (ctl.emit)
        begin
            rword_reg <= rdata;
        end
    end

    // result driven from captured state
    always_comb
    begin
        kind = kind_reg; req_bus = '0; req_slot = '0; req_func = '0; req_offset = '0;
        found = 1'b0; entry_index = '0; read_word = '0;
        device_count = 7'(count_reg);
        if (cmd_reg == CMD_FIND)
        begin
            kind = KIND_FIND;
            if (ofound_reg)
            begin
                found = 1'b1; entry_index = oidx_reg;
                req_bus = rword_reg[15:8]; req_slot = rword_reg[7:3];
                req_func = rword_reg[2:0];
            end
        end
        else if (cmd_reg == CMD_READ)
        begin
            if (es_ok && ws_ok)
            begin
                kind = KIND_WORD; read_word = rword_reg;
            end
            else
            begin
                kind = KIND_REJECT;
            end
        end
        else
        begin
            req_bus = obus_reg; req_slot = oslot_reg; req_func = ofunc_reg;
            req_offset = ooff_reg;
        end
        if (!out_valid_reg)
        begin
            kind = '0;
        end
    end
endmodule

// ===== hdl/cse_ctrl.sv =====
// ----------------------------------------------------------------------------
// cse_ctrl
// Sequencer for command transactions of the enumerator.
// ----------------------------------------------------------------------------
module cse_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         cmd,
    input  cse_pkg::cse_stat_t stat,
    input  logic               count_zero,
    output cse_pkg::cse_cmd_t  ctl,
    output logic               busy,
    output logic               done
);
    import cse_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_FRD  = 3'd2;
    localparam logic [2:0] S_FCHK = 3'd3;
    localparam logic [2:0] S_WRD  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;
    localparam logic [2:0] S_FPL  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] cmd_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load = 1'b1; state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd_reg)
                    CMD_FIND:
                    begin
                        if (count_zero)
                        begin
                            ctl.emit = 1'b1; state_next = S_OUT;
                        end
                        else
                        begin
                            ctl.find_rd = 1'b1; state_next = S_FCHK;
                        end
                    end
                    CMD_READ:
                    begin
                        ctl.word_rd = 1'b1; state_next = S_WRD;
                    end
                    default:
                    begin
                        ctl.reply = 1'b1; ctl.emit = 1'b1; state_next = S_OUT;
                    end
                endcase
            end
            S_FCHK:
            begin
                ctl.find_chk = 1'b1;
                if (stat.find_hit)
                begin
                    state_next = S_FPL;
                end
                else if (stat.find_last)
                begin
                    ctl.emit = 1'b1; state_next = S_OUT;
                end
                else
                begin
                    state_next = S_FRD;
                end
            end
            S_FRD:
            begin
                ctl.find_rd = 1'b1; state_next = S_FCHK;
            end
            S_FPL:
            begin
                ctl.emit = 1'b1; state_next = S_OUT;
            end
            S_WRD:
            begin
                ctl.emit = 1'b1; state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; cmd_reg <= CMD_START;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.load)
            begin
                cmd_reg <= cmd;
            end
        end
    end
endmodule

// ===== hdl/config_space_enumerator.sv =====
// ----------------------------------------------------------------------------
// config_space_enumerator
// Configuration space scan engine with device table, find and readback.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its one result
// appears for exactly one cycle with done high and must be taken then. Scan
// start and reply go from execute to output, readback adds a word read, and
// find on an empty table goes straight to output, else reads and checks one
// entry at a time, plus a place read on a match, as the entry table sits in a
// single port RAM. No clearing pass after reset.
module config_space_enumerator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_data,
    input  logic [1:0]  cmd,
    input  logic [31:0] reply_data,
    input  logic [15:0] want_vendor,
    input  logic [15:0] want_device,
    input  logic [5:0]  entry_select,
    input  logic [3:0]  word_select,
    output logic [2:0]  kind,
    output logic [7:0]  req_bus,
    output logic [4:0]  req_slot,
    output logic [2:0]  req_func,
    output logic [7:0]  req_offset,
    output logic        found,
    output logic [5:0]  entry_index,
    output logic [6:0]  device_count,
    output logic [31:0] read_word
);
    import cse_pkg::*;

    cse_cmd_t  ctl;
    cse_stat_t stat;

    cse_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd), .stat(stat),
        .count_zero(device_count == 7'd0), .ctl(ctl), .busy(busy), .done(done)
    );

    cse_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .stat(stat), .cmd(cmd),
        .reply_data(reply_data), .want_vendor(want_vendor), .want_device(want_device),
        .entry_select(entry_select), .word_select(word_select), .cfg_we(cfg_we),
        .cfg_data(cfg_data), .kind(kind), .req_bus(req_bus),
        .req_slot(req_slot), .req_func(req_func), .req_offset(req_offset),
        .found(found), .entry_index(entry_index), .device_count(device_count),
        .read_word(read_word)
    );
endmodule

// ===== hdl/cse_checker.sv =====
// ----------------------------------------------------------------------------
// cse_checker
// Port level checks of the enumerator, bound to the top level.
// ----------------------------------------------------------------------------
module cse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic [2:0] kind,
    input logic [6:0] device_count,
    input logic       found
);
    import cse_pkg::*;

    // a result only while a transaction is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result without transaction");

    // accepted transaction raises busy
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("transaction not taken");

    // result returns to idle
    a_release: assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("busy after result");

    // count never exceeds table size
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        device_count <= 7'(MaxDevices))
        else $error("device count out of range");

    // found only on a find answer
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (kind == KIND_FIND))
        else $error("found on wrong kind");
endmodule

bind config_space_enumerator cse_checker u_cse_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .kind(kind), .device_count(device_count), .found(found)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for config_space_enumerator: directed table of
// transactions, then random scans shaped by the tracked scan phase, with
// finds and readbacks mixed in and several table limits. Results checked
// against a predictor.
// ----------------------------------------------------------------------------
module tb_top;
    import cse_pkg::*;

    localparam int WdogLimit   = 5000;
    localparam int DrainCycles = 160;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  bus;
        logic [4:0]  slot;
        logic [2:0]  func;
        logic [7:0]  offset;
        logic        found;
        logic [5:0]  idx;
        logic [6:0]  count;
        logic [31:0] word;
    } res_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] data;
        logic [15:0] wv;
        logic [15:0] wd;
        logic [5:0]  es;
        logic [3:0]  ws;
    } item_t;

    typedef struct packed {
        item_t it;
        logic  typed;
        res_t  exp;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic        cfg_we;
    logic [6:0]  cfg_data;
    logic [1:0]  cmd;
    logic [31:0] reply_data;
    logic [15:0] want_vendor;
    logic [15:0] want_device;
    logic [5:0]  entry_select;
    logic [3:0]  word_select;
    logic [2:0]  kind;
    logic [7:0]  req_bus;
    logic [4:0]  req_slot;
    logic [2:0]  req_func;
    logic [7:0]  req_offset;
    logic        found;
    logic [5:0]  entry_index;
    logic [6:0]  device_count;
    logic [31:0] read_word;

    config_space_enumerator i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .reply_data   (reply_data),
        .want_vendor  (want_vendor),
        .want_device  (want_device),
        .entry_select (entry_select),
        .word_select  (word_select),
        .kind         (kind),
        .req_bus      (req_bus),
        .req_slot     (req_slot),
        .req_func     (req_func),
        .req_offset   (req_offset),
        .found        (found),
        .entry_index  (entry_index),
        .device_count (device_count),
        .read_word    (read_word)
    );

    // predictor state
    logic [6:0]  limit_reg;
    logic [7:0]  s_bus;
    logic [4:0]  s_slot;
    logic [2:0]  s_func;
    logic [2:0]  s_phase;
    logic [2:0]  s_bar;
    logic        s_multi;
    logic [6:0]  s_count;
    logic [31:0] tbl_ids   [MaxDevices];
    logic [15:0] tbl_place [MaxDevices];
    logic [31:0] tbl_class [MaxDevices];
    logic [31:0] tbl_bars  [MaxDevices*6];
    logic [7:0]  tbl_irq   [MaxDevices];

    res_t expected_q[$];
    int   n_fail;
    int   n_items;
    int   n_done;
    int   n_hits;
    int   n_words;
    int   idle_cnt;

    // clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic res_t blank_res(logic [2:0] k);
        res_t r;
        r = '0;
        r.kind  = k;
        r.count = s_count;
        return r;
    endfunction

    function automatic res_t issue_read(logic [7:0] off, logic [2:0] ph);
        res_t r;
        s_phase  = ph;
        r        = blank_res(KIND_REQ);
        r.bus    = s_bus;
        r.slot   = s_slot;
        r.func   = s_func;
        r.offset = off & 8'hFC;
        return r;
    endfunction

    function automatic res_t step_slot();
        s_func  = 3'd0;
        s_multi = 1'b0;
        if (s_slot < 5'd31) begin
            s_slot++;
        end else begin
            s_slot = 5'd0;
            if (s_bus < 8'd255) begin
                s_bus++;
            end else begin
                s_bus   = 8'd0;
                s_phase = PH_IDLE;
                return blank_res(KIND_DONE);
            end
        end
        return issue_read(8'h00, PH_PROBE_ID);
    endfunction

    function automatic res_t step_func();
        if (s_func == 3'd7 || (s_func == 3'd0 && !s_multi))
            return step_slot();
        s_func++;
        return issue_read(8'h00, PH_FN_ID);
    endfunction

    // one scan step for a config read reply
    function automatic res_t take_reply(logic [31:0] d);
        logic [6:0] n;
        logic [6:0] lim;
        n   = s_count;
        lim = (limit_reg < MaxDevices) ? limit_reg : 7'(MaxDevices);
        case (s_phase)
            PH_PROBE_ID:
                return (d[15:0] == 16'hFFFF) ? step_slot() : issue_read(8'h0C, PH_PROBE_HDR);
            PH_PROBE_HDR:
            begin
                s_multi = d[23];
                s_func  = 3'd0;
                return issue_read(8'h00, PH_FN_ID);
            end
            PH_FN_ID:
            begin
                if (d[15:0] == 16'hFFFF || n >= lim)
                    return step_func();
                tbl_ids[n[5:0]]   = d;
                tbl_place[n[5:0]] = {s_bus, s_slot, s_func};
                return issue_read(8'h08, PH_FN_CLASS);
            end
            PH_FN_CLASS:
            begin
                tbl_class[n[5:0]] = {d[31:8], 8'h00};
                return issue_read(8'h0C, PH_FN_HDR);
            end
            PH_FN_HDR:
            begin
                tbl_class[n[5:0]][7:0] = d[23:16];
                s_bar = 3'd0;
                return issue_read(8'h10, PH_FN_BAR);
            end
            PH_FN_BAR:
            begin
                tbl_bars[n[5:0]*6 + s_bar] = d;
                if (s_bar < 3'd5) begin
                    s_bar++;
                    return issue_read(8'h10 + 8'(s_bar) * 8'd4, PH_FN_BAR);
                end
                return issue_read(8'h3C, PH_FN_IRQ);
            end
            PH_FN_IRQ:
            begin
                tbl_irq[n[5:0]] = d[7:0];
                s_count = n + 7'd1;
                return step_func();
            end
            default:
                return blank_res(KIND_REJECT);
        endcase
    endfunction

    // full predictor for one accepted transaction
    function automatic res_t predict_result(item_t it);
        res_t r;
        if (it.cmd == CMD_START) begin
            s_bus   = '0;
            s_slot  = '0;
            s_func  = '0;
            s_bar   = '0;
            s_multi = 1'b0;
            s_count = '0;
            return issue_read(8'h00, PH_PROBE_ID);
        end
        if (it.cmd == CMD_REPLY)
            return take_reply(it.data);
        if (it.cmd == CMD_FIND) begin
            r = blank_res(KIND_FIND);
            for (int i = 0; i < s_count; i++) begin
                if (tbl_ids[i] == {it.wd, it.wv}) begin
                    {r.bus, r.slot, r.func} = tbl_place[i];
                    r.found = 1'b1;
                    r.idx   = 6'(i);
                    break;
                end
            end
            return r;
        end
        if (it.es >= s_count || it.ws > W_IRQ)
            return blank_res(KIND_REJECT);
        r = blank_res(KIND_WORD);
        case (it.ws)
            W_IDS:   r.word = tbl_ids[it.es];
            W_PLACE: r.word = {16'h0, tbl_place[it.es]};
            W_CLASS: r.word = tbl_class[it.es];
            W_IRQ:   r.word = {24'h0, tbl_irq[it.es]};
            default: r.word = tbl_bars[it.es*6 + (it.ws - W_BAR0)];
        endcase
        return r;
    endfunction

    // send one transaction, hold it until taken, then queue its result
    task automatic send_item(item_t it, logic typed, res_t typed_exp);
        res_t r;
        @(negedge clk);
        cmd          = it.cmd;
        reply_data   = it.data;
        want_vendor  = it.wv;
        want_device  = it.wd;
        entry_select = it.es;
        word_select  = it.ws;
        start        = 1'b1;
        do @(posedge clk); while (busy);
        r = predict_result(it);
        expected_q.push_back(typed ? typed_exp : r);
        n_items++;
    endtask

    task automatic random_gap();
        int p;
        int n;
        p = $urandom_range(99);
        n = (p < 60) ? 0 : (p < 90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
        if (n > 0) begin
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // pause until every result is in, let the engine settle, then write
    task automatic write_limit(logic [6:0] v);
        @(negedge clk);
        start = 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_data  = v;
        limit_reg = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // random transaction shaped by where the scan stands
    function automatic item_t make_item(int absent_pct);
        item_t it;
        int    p;
        it.cmd  = CMD_REPLY;
        it.data = $urandom();
        it.wv   = 16'($urandom());
        it.wd   = 16'($urandom());
        it.es   = 6'($urandom());
        it.ws   = 4'($urandom());
        p = $urandom_range(99);
        if (p < 4)
            return {2'($urandom()), it.data, it.wv, it.wd, it.es, it.ws};
        if (p < 10) begin
            it.cmd = CMD_FIND;
            if (s_count != 0 && $urandom_range(3) != 0)
                {it.wd, it.wv} = tbl_ids[$urandom_range(s_count - 1)];
            return it;
        end
        if (p < 17) begin
            it.cmd = CMD_READ;
            it.es  = 6'($urandom_range(s_count + 1));
            it.ws  = 4'($urandom_range(11));
            return it;
        end
        if (s_phase == PH_IDLE || p == 17) begin
            it.cmd = CMD_START;
            return it;
        end
        if ((s_phase == PH_PROBE_ID || s_phase == PH_FN_ID)) begin
            if ($urandom_range(99) < absent_pct)
                it.data[15:0] = 16'hFFFF;
            else if ($urandom_range(1))
                it.data = {16'h1000 + 16'($urandom_range(3)), 16'h8086};
            else if (it.data[15:0] == 16'hFFFF)
                it.data[0] = 1'b0;
        end
        return it;
    endfunction

    // result checker
    always @(posedge clk) begin
        res_t got;
        res_t exp;
        if (rst_n && done) begin
            got = {kind, req_bus, req_slot, req_func, req_offset, found, entry_index,
                   device_count, read_word};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result kind=%0d", $time, kind);
                n_fail++;
            end else begin
                exp = expected_q.pop_front();
                if (got.kind == KIND_DONE) n_done++;
                if (got.kind == KIND_WORD) n_words++;
                if (got.found) n_hits++;
                if (got !== exp) begin
                    $display("%0t: mismatch exp kind=%0d loc=%0d.%0d.%0d off=%h fnd=%b idx=%0d cnt=%0d word=%h",
                             $time, exp.kind, exp.bus, exp.slot, exp.func, exp.offset,
                             exp.found, exp.idx, exp.count, exp.word);
                    $display("%0t:          got kind=%0d loc=%0d.%0d.%0d off=%h fnd=%b idx=%0d cnt=%0d word=%h",
                             $time, got.kind, got.bus, got.slot, got.func, got.offset,
                             got.found, got.idx, got.count, got.word);
                    n_fail++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WdogLimit) begin
            $display("config_space_enumerator regression: fail");
            $finish;
        end
    end

    // stimulus
    initial begin
        row_t        rows[$];
        res_t        e;
        logic [6:0]  limits[6];
        int          target;
        n_fail = 0;
        n_items = 0;
        n_done = 0;
        n_hits = 0;
        n_words = 0;
        idle_cnt = 0;
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        cmd = CMD_START;
        reply_data = '0;
        want_vendor = '0;
        want_device = '0;
        entry_select = '0;
        word_select = '0;
        limit_reg = 7'd64;
        s_bus = '0;
        s_slot = '0;
        s_func = '0;
        s_phase = PH_IDLE;
        s_bar = '0;
        s_multi = 1'b0;
        s_count = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        e = '0;
        e.kind = KIND_REJECT;
        rows.push_back('{'{CMD_REPLY, 32'h0, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b1, e});
        rows.push_back('{'{CMD_READ, 32'h0, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b1, e});
        e.kind = KIND_FIND;
        rows.push_back('{'{CMD_FIND, 32'h0, 16'hFFFF, 16'hFFFF, 6'd0, W_IDS}, 1'b1, e});
        e.kind = KIND_REQ;
        rows.push_back('{'{CMD_START, 32'h0, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b1, e});
        rows.push_back('{'{CMD_REPLY, 32'hFFFF_FFFF, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'h1234_10EC, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'h0080_0000, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'h1234_10EC, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'h0C03_3001, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'h0080_0000, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'hFFFF_FFFF, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'h0000_0000, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'hFEBF_0000, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'h0000_0001, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'h8000_0000, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'h7FFF_FFFF, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'h0000_01FF, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_REPLY, 32'h0000_FFFF, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e});
        rows.push_back('{'{CMD_READ, 32'h0, 16'h0, 16'h0, 6'd0, W_IRQ}, 1'b0, e});
        rows.push_back('{'{CMD_READ, 32'h0, 16'h0, 16'h0, 6'd0, W_CLASS}, 1'b0, e});
        rows.push_back('{'{CMD_FIND, 32'h0, 16'h10EC, 16'h1234, 6'd0, W_IDS}, 1'b0, e});
        e.kind  = KIND_REJECT;
        e.count = 7'd1;
        rows.push_back('{'{CMD_READ, 32'h0, 16'h0, 16'h0, 6'd0, 4'd10}, 1'b1, e});
        rows.push_back('{'{CMD_READ, 32'h0, 16'h0, 16'h0, 6'd0, 4'd15}, 1'b1, e});
        rows.push_back('{'{CMD_READ, 32'h0, 16'h0, 16'h0, 6'd1, W_IDS}, 1'b1, e});
        rows.push_back('{'{CMD_READ, 32'h0, 16'h0, 16'h0, 6'd63, W_BAR0}, 1'b1, e});
        foreach (rows[i])
            send_item(rows[i].it, rows[i].typed, rows[i].exp);

        // random phases under several table limits
        limits = '{7'd64, 7'd0, 7'd127, 7'd1, 7'd5, 7'($urandom_range(127))};
        foreach (limits[k]) begin
            write_limit(limits[k]);
            target = n_items + 310;
            send_item('{CMD_START, 32'h0, 16'h0, 16'h0, 6'd0, W_IDS}, 1'b0, e);
            while (n_items < target) begin
                random_gap();
                send_item(make_item(k == 0 ? 20 : 45), 1'b0, e);
            end
        end

        @(negedge clk);
        start = 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        $display("covered %0d transactions, %0d scan completions, %0d find hits, %0d table reads",
                 n_items, n_done, n_hits, n_words);
        $display("table limits 0, 1, 5, 64, 127 and a random one, with scan restarts");
        if (n_fail == 0)
            $display("config_space_enumerator regression: pass");
        else
            $display("config_space_enumerator regression: fail");
        $finish;
    end

endmodule
